// ===== hw/rtl/fixed_partition_fit_allocator_defines.svh =====
// Assertion helpers for the partition allocator
`ifndef FIXED_PARTITION_FIT_ALLOCATOR_DEFINES_SVH
`define FIXED_PARTITION_FIT_ALLOCATOR_DEFINES_SVH

// Clocked assertion with explicit clock and active-low reset
`define FPFA_ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("fpfa assertion failed");

// Same, on the block clock and reset
`define FPFA_ASSERT(label, prop) \
  `FPFA_ASSERT_CLK(label, clk_i, rst_ni, prop)

`endif

// ===== hw/rtl/fpfa_pkg.sv =====
package fpfa_pkg;

  localparam int unsigned MAX_BLOCKS_DEF = 16;
  localparam int unsigned SIZE_BITS_DEF  = 16;

  localparam int unsigned KIND_W     = 2;
  localparam int unsigned IDX_W      = 4;
  localparam int unsigned VAL_W      = 16;
  localparam int unsigned CHOSEN_W   = 4;
  localparam int unsigned LEFT_W     = 16;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 5;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned ACT_W      = 5;

  localparam logic [ACT_W-1:0] ACT_RESET = 5'd16;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD  = 2'd0,
    KIND_REQ   = 2'd1,
    KIND_CLEAR = 2'd2
  } fpfa_kind_e;

  typedef enum logic [MODE_W-1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_WORST = 2'd2
  } fpfa_fit_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIT_MODE = 4'd0,
    CFG_ACTIVE   = 4'd1
  } fpfa_cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } fpfa_state_e;

  typedef struct packed {
    logic [MODE_W-1:0] fit_mode;
    logic [ACT_W-1:0]  active;
  } fpfa_cfg_t;

  typedef struct packed {
    logic                granted;
    logic [CHOSEN_W-1:0] chosen_block;
    logic [LEFT_W-1:0]   leftover;
  } fpfa_res_t;

endpackage

// ===== hw/rtl/fpfa_req_if.sv =====
interface fpfa_req_if
  import fpfa_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [IDX_W-1:0]  block_index;
  logic [VAL_W-1:0]  size_value;

  modport source (output valid, kind, block_index, size_value, input ready);
  modport sink   (input valid, kind, block_index, size_value, output ready);
endinterface

// ===== hw/rtl/fpfa_res_if.sv =====
interface fpfa_res_if
  import fpfa_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                granted;
  logic [CHOSEN_W-1:0] chosen_block;
  logic [LEFT_W-1:0]   leftover;

  modport source (output valid, granted, chosen_block, leftover, input ready);
  modport sink   (input valid, granted, chosen_block, leftover, output ready);
endinterface

// ===== hw/rtl/fpfa_cfg_if.sv =====
interface fpfa_cfg_if
  import fpfa_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/fixed_partition_fit_allocator.sv =====
// Fixed-partition allocator. Requests are taken one at a time. A size load, a
// clear of the used marks or an unused kind goes straight to the emit state. An
// allocation request walks the partition size memory through its single read
// port, one partition per cycle, over the first N partitions, where N is the
// active setting capped at MAX_BLOCKS. Every request gives one response, held
// in an output register so the next request can be taken while it waits.
// Partition sizes are undefined until loaded; used marks clear on reset.
// Configuration writes are taken at any time and must only be issued idle.
module fixed_partition_fit_allocator
  import fpfa_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = MAX_BLOCKS_DEF,
  parameter int unsigned SIZE_BITS  = SIZE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  fpfa_req_if.sink    req_i,
  fpfa_res_if.source  res_o,
  fpfa_cfg_if.sink    cfg_i
);

  localparam int unsigned AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

  logic [MODE_W-1:0] fit_mode_q, fit_mode_d;
  logic [ACT_W-1:0]  active_q, active_d;
  fpfa_cfg_t         cfg;

  logic      out_valid_q, out_valid_d;
  fpfa_res_t out_q, out_d;
  logic      out_free;
  logic      res_valid;
  fpfa_res_t res;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [SIZE_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [AW-1:0]        ram_raddr;
  logic [SIZE_BITS-1:0] ram_rdata;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    fit_mode_d = fit_mode_q;
    active_d   = active_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_FIT_MODE: fit_mode_d = cfg_i.data[MODE_W-1:0];
        CFG_ACTIVE:   active_d   = cfg_i.data[ACT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.fit_mode = fit_mode_q;
  assign cfg.active   = active_q;

  assign out_free    = !out_valid_q || res_o.ready;
  assign out_valid_d = res_valid || (out_valid_q && !res_o.ready);
  assign out_d       = res_valid ? res : out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_mode_q  <= FIT_FIRST;
      active_q    <= ACT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      fit_mode_q  <= fit_mode_d;
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.granted      = out_q.granted;
  assign res_o.chosen_block = out_q.chosen_block;
  assign res_o.leftover     = out_q.leftover;

  fpfa_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (MAX_BLOCKS)
  ) u_size_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  fpfa_ctrl #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .req_valid_i       (req_i.valid),
    .req_kind_i        (req_i.kind),
    .req_block_index_i (req_i.block_index),
    .req_size_value_i  (req_i.size_value),
    .req_ready_o       (req_i.ready),
    .cfg_i             (cfg),
    .out_free_i        (out_free),
    .res_valid_o       (res_valid),
    .res_o             (res),
    .ram_we_o          (ram_we),
    .ram_waddr_o       (ram_waddr),
    .ram_wdata_o       (ram_wdata),
    .ram_re_o          (ram_re),
    .ram_raddr_o       (ram_raddr),
    .ram_rdata_i       (ram_rdata)
  );

endmodule

// ===== hw/rtl/fpfa_ram.sv =====
module fpfa_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/fpfa_ctrl.sv =====
module fpfa_ctrl
  import fpfa_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = MAX_BLOCKS_DEF,
  parameter int unsigned SIZE_BITS  = SIZE_BITS_DEF,
  localparam int unsigned AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  input  logic [KIND_W-1:0]    req_kind_i,
  input  logic [IDX_W-1:0]     req_block_index_i,
  input  logic [VAL_W-1:0]     req_size_value_i,
  output logic                 req_ready_o,
  input  fpfa_cfg_t            cfg_i,
  input  logic                 out_free_i,
  output logic                 res_valid_o,
  output fpfa_res_t            res_o,
  output logic                 ram_we_o,
  output logic [AW-1:0]        ram_waddr_o,
  output logic [SIZE_BITS-1:0] ram_wdata_o,
  output logic                 ram_re_o,
  output logic [AW-1:0]        ram_raddr_o,
  input  logic [SIZE_BITS-1:0] ram_rdata_i
);

  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned W  = (SIZE_BITS > VAL_W) ? SIZE_BITS : VAL_W;
  localparam int unsigned PW = (AW > CHOSEN_W) ? AW : CHOSEN_W;

  fpfa_state_e state_q, state_d;

  logic [CW-1:0]         rd_q, rd_d;
  logic [CW-1:0]         cmp_q, cmp_d;
  logic                  cmp_vld_q, cmp_vld_d;
  logic [VAL_W-1:0]      val_q, val_d;
  logic                  found_q, found_d;
  logic [AW-1:0]         pick_q, pick_d;
  logic [W-1:0]          left_q, left_d;
  logic [MAX_BLOCKS-1:0] used_q, used_d;
  fpfa_res_t             res_q, res_d;

  logic          accept;
  logic [CW-1:0] count;
  logic [7:0]    act_ext;
  logic          in_range;
  logic          issue;
  logic          last_cmp;
  logic [W-1:0]  size_w;
  logic [W-1:0]  diff_w;
  logic          fits;
  logic          take;
  logic          fin_found;
  logic [AW-1:0] fin_pick;
  logic [W-1:0]  fin_left;
  logic [PW-1:0] pick_ext;

  assign accept   = req_valid_i && req_ready_o;
  assign act_ext  = 8'(cfg_i.active);
  assign count    = (act_ext > 8'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : CW'(act_ext);
  assign in_range = 8'(req_block_index_i) < 8'(MAX_BLOCKS);
  assign issue    = (state_q == ST_SCAN) && (rd_q < count);
  assign last_cmp = cmp_vld_q && (CW'(cmp_q + CW'(1)) == count);

  assign size_w = W'(ram_rdata_i);
  assign diff_w = size_w - W'(val_q);
  assign fits   = cmp_vld_q && !used_q[cmp_q[AW-1:0]] && (size_w >= W'(val_q));
  assign take   = fits && (!found_q
                  || (cfg_i.fit_mode == FIT_BEST  && diff_w < left_q)
                  || (cfg_i.fit_mode == FIT_WORST && diff_w > left_q));

  assign fin_found = found_q || take;
  assign fin_pick  = take ? cmp_q[AW-1:0] : pick_q;
  assign fin_left  = take ? diff_w : left_q;
  assign pick_ext  = PW'(fin_pick);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (req_kind_i == KIND_REQ && count != '0) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_SCAN: begin
        if (last_cmp) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    req_ready_o = (state_q == ST_IDLE);
    res_valid_o = (state_q == ST_EMIT) && out_free_i;
    res_o       = res_q;
    ram_we_o    = accept && (req_kind_i == KIND_LOAD) && in_range;
    ram_waddr_o = AW'(req_block_index_i);
    ram_wdata_o = SIZE_BITS'(req_size_value_i);
    ram_re_o    = issue;
    ram_raddr_o = rd_q[AW-1:0];
  end

  // datapath
  always_comb begin
    rd_d      = rd_q;
    cmp_d     = rd_q;
    cmp_vld_d = issue;
    val_d     = val_q;
    found_d   = found_q;
    pick_d    = pick_q;
    left_d    = left_q;
    used_d    = used_q;
    res_d     = res_q;
    if (accept) begin
      rd_d    = '0;
      val_d   = req_size_value_i;
      found_d = 1'b0;
      pick_d  = '0;
      left_d  = '0;
      res_d   = '0;
      if (req_kind_i == KIND_CLEAR) begin
        used_d = '0;
      end
    end
    if (issue) begin
      rd_d = CW'(rd_q + CW'(1));
    end
    if (state_q == ST_SCAN && cmp_vld_q) begin
      found_d = fin_found;
      pick_d  = fin_pick;
      left_d  = fin_left;
      if (last_cmp && fin_found) begin
        used_d[fin_pick]   = 1'b1;
        res_d.granted      = 1'b1;
        res_d.chosen_block = pick_ext[CHOSEN_W-1:0];
        res_d.leftover     = fin_left[LEFT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cmp_vld_q <= 1'b0;
      used_q    <= '0;
    end else begin
      state_q   <= state_d;
      cmp_vld_q <= cmp_vld_d;
      used_q    <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q    <= rd_d;
    cmp_q   <= cmp_d;
    val_q   <= val_d;
    found_q <= found_d;
    pick_q  <= pick_d;
    left_q  <= left_d;
    res_q   <= res_d;
  end

endmodule

// ===== hw/rtl/fpfa_checker.sv =====
`include "fixed_partition_fit_allocator_defines.svh"

module fpfa_checker
  import fpfa_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                req_valid,
  input logic                req_ready,
  input logic                res_valid,
  input logic                res_ready,
  input logic                res_granted,
  input logic [CHOSEN_W-1:0] res_chosen_block,
  input logic [LEFT_W-1:0]   res_leftover
);

  // one request in flight at a time
  `FPFA_ASSERT(a_one_at_a_time, (req_valid && req_ready) |=> !req_ready)

  // a refused allocation reports nothing
  `FPFA_ASSERT(a_no_grant_zero, (res_valid && !res_granted) |-> (res_chosen_block == '0 && res_leftover == '0))

  // a response cannot appear without a request having been taken before
  `FPFA_ASSERT(a_res_after_req, $rose(res_valid) |-> !$past(req_ready))

  `FPFA_ASSERT(a_res_hold, (res_valid && !res_ready) |=> (res_valid && $stable(res_granted) && $stable(res_chosen_block) && $stable(res_leftover)))

endmodule

bind fixed_partition_fit_allocator fpfa_checker u_fpfa_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid        (req_i.valid),
  .req_ready        (req_i.ready),
  .res_valid        (res_o.valid),
  .res_ready        (res_o.ready),
  .res_granted      (res_o.granted),
  .res_chosen_block (res_o.chosen_block),
  .res_leftover     (res_o.leftover)
);
